[rtl/clld_pkg.sv]
package clld_pkg;

  localparam int ID_W    = 10;
  localparam int KIND_W  = 3;
  localparam int NUM_IDS = 2 ** ID_W;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD     = 3'd0;
  localparam kind_t KIND_INS_NEXT = 3'd1;
  localparam kind_t KIND_INS_PREV = 3'd2;
  localparam kind_t KIND_REM_NEXT = 3'd3;
  localparam kind_t KIND_REM_PREV = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_NEXT,
    OP_INS_PREV,
    OP_REM_NEXT,
    OP_REM_PREV
  } op_t;

  typedef struct packed {
    logic take;
    logic step2;
    logic step3;
    logic res_load;
  } ctrl_t;

  typedef struct packed {
    op_t in_op;
    op_t op;
  } stat_t;

  function automatic op_t decode_kind(input kind_t kind);
    op_t op;
    case (kind)
      KIND_LOAD:     op = OP_LOAD;
      KIND_INS_NEXT: op = OP_INS_NEXT;
      KIND_INS_PREV: op = OP_INS_PREV;
      KIND_REM_NEXT: op = OP_REM_NEXT;
      KIND_REM_PREV: op = OP_REM_PREV;
      default:       op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

[rtl/clld_in_if.sv]
interface clld_in_if;
  logic             valid;
  logic             ready;
  clld_pkg::kind_t  kind;
  clld_pkg::id_t    ref_id;
  clld_pkg::id_t    new_id;

  modport source (output valid, output kind, output ref_id, output new_id, input ready);
  modport sink (input valid, input kind, input ref_id, input new_id, output ready);
endinterface

[rtl/clld_out_if.sv]
interface clld_out_if;
  logic           valid;
  logic           ready;
  clld_pkg::id_t  neighbor_id;

  modport source (output valid, output neighbor_id, input ready);
  modport sink (input valid, input neighbor_id, output ready);
endinterface

[rtl/clld_ctrl.sv]
module clld_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  clld_pkg::stat_t stat,
  output clld_pkg::ctrl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_STEP2 = 3'b010,
    S_STEP3 = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   blocked;

  assign blocked  = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          if (stat.in_op != clld_pkg::OP_NONE) begin
            state_next = S_STEP2;
          end
        end
      end
      S_STEP2: begin
        ctl.step2  = 1'b1;
        state_next = (stat.op == clld_pkg::OP_LOAD) ? S_IDLE : S_STEP3;
      end
      S_STEP3: begin
        // hold until the previous result beat is taken
        if (!blocked) begin
          ctl.step3    = 1'b1;
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = blocked || ctl.res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/clld_dpath.sv]
module clld_dpath (
  input  logic            clk,
  input  logic            rst,
  input  clld_pkg::ctrl_t ctl,
  input  clld_pkg::kind_t in_kind,
  input  clld_pkg::id_t   in_ref,
  input  clld_pkg::id_t   in_nid,
  output clld_pkg::stat_t stat,
  output clld_pkg::id_t   neighbor_id
);

  clld_pkg::id_t next_mem [clld_pkg::NUM_IDS];
  clld_pkg::id_t prev_mem [clld_pkg::NUM_IDS];

  clld_pkg::op_t in_op;
  clld_pkg::op_t op;
  clld_pkg::id_t ref_q;
  clld_pkg::id_t nid_q;
  clld_pkg::id_t nb_q;
  clld_pkg::id_t first_entry;
  clld_pkg::id_t last_loaded;
  logic          ring_started;
  clld_pkg::id_t neighbor;

  logic          nxt_we, nxt_re, prv_we, prv_re;
  clld_pkg::id_t nxt_addr, nxt_wd, nxt_rd;
  clld_pkg::id_t prv_addr, prv_wd, prv_rd;
  logic          side_next;

  assign in_op       = clld_pkg::decode_kind(in_kind);
  assign stat.in_op  = in_op;
  assign stat.op     = op;
  assign neighbor_id = neighbor;
  assign side_next   = (op == clld_pkg::OP_INS_NEXT) || (op == clld_pkg::OP_REM_NEXT);

  always_comb begin
    nxt_we   = 1'b0;
    nxt_re   = 1'b0;
    nxt_addr = '0;
    nxt_wd   = '0;
    prv_we   = 1'b0;
    prv_re   = 1'b0;
    prv_addr = '0;
    prv_wd   = '0;
    if (ctl.take) begin
      case (in_op)
        clld_pkg::OP_LOAD: begin
          // link after the last loaded id
          if (ring_started) begin
            nxt_we   = 1'b1;
            nxt_addr = last_loaded;
            nxt_wd   = in_nid;
            prv_we   = 1'b1;
            prv_addr = in_nid;
            prv_wd   = last_loaded;
          end
        end
        clld_pkg::OP_INS_NEXT, clld_pkg::OP_REM_NEXT: begin
          nxt_re   = 1'b1;
          nxt_addr = in_ref;
        end
        clld_pkg::OP_INS_PREV, clld_pkg::OP_REM_PREV: begin
          prv_re   = 1'b1;
          prv_addr = in_ref;
        end
        default: ;
      endcase
    end else if (ctl.step2) begin
      case (op)
        clld_pkg::OP_LOAD: begin
          // close the ring back to the first id
          nxt_we   = 1'b1;
          nxt_addr = nid_q;
          nxt_wd   = first_entry;
          prv_we   = 1'b1;
          prv_addr = first_entry;
          prv_wd   = nid_q;
        end
        clld_pkg::OP_INS_NEXT: begin
          nxt_we   = 1'b1;
          nxt_addr = ref_q;
          nxt_wd   = nid_q;
          prv_we   = 1'b1;
          prv_addr = nid_q;
          prv_wd   = ref_q;
        end
        clld_pkg::OP_INS_PREV: begin
          nxt_we   = 1'b1;
          nxt_addr = prv_rd;
          nxt_wd   = nid_q;
          prv_we   = 1'b1;
          prv_addr = nid_q;
          prv_wd   = prv_rd;
        end
        clld_pkg::OP_REM_NEXT: begin
          nxt_re   = 1'b1;
          nxt_addr = nxt_rd;
        end
        clld_pkg::OP_REM_PREV: begin
          prv_re   = 1'b1;
          prv_addr = prv_rd;
        end
        default: ;
      endcase
    end else if (ctl.step3) begin
      case (op)
        clld_pkg::OP_INS_NEXT: begin
          nxt_we   = 1'b1;
          nxt_addr = nid_q;
          nxt_wd   = nb_q;
          prv_we   = 1'b1;
          prv_addr = nb_q;
          prv_wd   = nid_q;
        end
        clld_pkg::OP_INS_PREV: begin
          nxt_we   = 1'b1;
          nxt_addr = nid_q;
          nxt_wd   = ref_q;
          prv_we   = 1'b1;
          prv_addr = ref_q;
          prv_wd   = nid_q;
        end
        clld_pkg::OP_REM_NEXT: begin
          // far neighbor sits in the read register
          nxt_we   = 1'b1;
          nxt_addr = ref_q;
          nxt_wd   = nxt_rd;
          prv_we   = 1'b1;
          prv_addr = nxt_rd;
          prv_wd   = ref_q;
        end
        clld_pkg::OP_REM_PREV: begin
          nxt_we   = 1'b1;
          nxt_addr = prv_rd;
          nxt_wd   = ref_q;
          prv_we   = 1'b1;
          prv_addr = ref_q;
          prv_wd   = prv_rd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_addr] <= nxt_wd;
    end
    if (nxt_re) begin
      nxt_rd <= next_mem[nxt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prev_mem[prv_addr] <= prv_wd;
    end
    if (prv_re) begin
      prv_rd <= prev_mem[prv_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op           <= clld_pkg::OP_NONE;
      first_entry  <= '0;
      last_loaded  <= '0;
      ring_started <= 1'b0;
    end else if (ctl.take) begin
      op <= in_op;
      if (in_op == clld_pkg::OP_LOAD) begin
        if (!ring_started) begin
          first_entry <= in_nid;
        end
        ring_started <= 1'b1;
        last_loaded  <= in_nid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      ref_q <= in_ref;
      nid_q <= in_nid;
    end
    if (ctl.step2) begin
      nb_q <= side_next ? nxt_rd : prv_rd;
    end
    if (ctl.res_load) begin
      neighbor <= nb_q;
    end
  end

endmodule

[rtl/circular_linked_list_by_id_top.sv]
// channel   dir  beat fields
// items     in   kind, ref_id, new_id
// results   out  neighbor_id
//
// an insert or remove holds the input over take, step2 and step3 and shows
// its result once step3 loads it; a load holds it over take and step2, an
// unknown kind over take alone; set by the single-port next and prev tables
// insert: read, write pair, write pair; remove: read, read, write pair
// rst is synchronous; table contents are not cleared, ring registers are
// a result waiting on results.ready holds the last step of the next item

module circular_linked_list_by_id_top (
  input  logic      clk,
  input  logic      rst,
  clld_in_if.sink   items,
  clld_out_if.source results
);

  clld_pkg::ctrl_t ctl;
  clld_pkg::stat_t stat;
  logic            in_ready;
  logic            out_valid;
  clld_pkg::id_t   neighbor_id;

  clld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  clld_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .in_kind     (items.kind),
    .in_ref      (items.ref_id),
    .in_nid      (items.new_id),
    .stat        (stat),
    .neighbor_id (neighbor_id)
  );

  assign items.ready         = in_ready;
  assign results.valid       = out_valid;
  assign results.neighbor_id = neighbor_id;

  a_step3_has_result: assert property (@(posedge clk) disable iff (rst)
    ctl.step3 |-> (stat.op != clld_pkg::OP_LOAD && stat.op != clld_pkg::OP_NONE))
    else $error("final step on an op without a result");

  a_load_two_steps: assert property (@(posedge clk) disable iff (rst)
    ctl.take && stat.in_op == clld_pkg::OP_LOAD |=> ctl.step2)
    else $error("load did not close the ring next cycle");

  a_no_accept_midway: assert property (@(posedge clk) disable iff (rst)
    ctl.step2 && stat.op != clld_pkg::OP_LOAD |=> !items.ready)
    else $error("accepted a beat before the last step");

  a_result_after_step3: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |=> results.valid)
    else $error("result beat not presented");

endmodule

[bench/circular_linked_list_by_id_top_tb.sv]
module circular_linked_list_by_id_top_tb;

  localparam int              PERIOD_HALF    = 6;
  localparam int              LATENCY        = 6;
  localparam int              STALL_LIMIT    = 4000;
  localparam int              PHASE_ITEMS    = 475;
  localparam clld_pkg::kind_t KIND_SPARE_LO  = 3'd5;
  localparam clld_pkg::kind_t KIND_SPARE_MID = 3'd6;
  localparam clld_pkg::kind_t KIND_SPARE_HI  = 3'd7;

  typedef struct packed {
    clld_pkg::kind_t k;
    clld_pkg::id_t   ref_v;
    clld_pkg::id_t   new_v;
    logic            typed;
    clld_pkg::id_t   want;
  } plan_row_t;

  localparam plan_row_t PLAN [18] = '{
    '{clld_pkg::KIND_LOAD,     10'd0,    10'd5,    1'b0, 10'd0},
    '{clld_pkg::KIND_INS_NEXT, 10'd5,    10'd1023, 1'b1, 10'd5},
    '{clld_pkg::KIND_INS_PREV, 10'd5,    10'd0,    1'b1, 10'd1023},
    '{clld_pkg::KIND_REM_NEXT, 10'd1023, 10'd0,    1'b1, 10'd0},
    '{clld_pkg::KIND_REM_PREV, 10'd5,    10'd1023, 1'b1, 10'd1023},
    '{clld_pkg::KIND_REM_NEXT, 10'd5,    10'd0,    1'b1, 10'd5},
    '{clld_pkg::KIND_REM_PREV, 10'd5,    10'd1023, 1'b1, 10'd5},
    '{KIND_SPARE_LO,           10'd1023, 10'd1023, 1'b0, 10'd0},
    '{KIND_SPARE_MID,          10'd682,  10'd341,  1'b0, 10'd0},
    '{KIND_SPARE_HI,           10'd341,  10'd682,  1'b0, 10'd0},
    '{clld_pkg::KIND_LOAD,     10'd1023, 10'd1023, 1'b0, 10'd0},
    '{clld_pkg::KIND_LOAD,     10'd341,  10'd682,  1'b0, 10'd0},
    '{clld_pkg::KIND_LOAD,     10'd682,  10'd341,  1'b0, 10'd0},
    '{clld_pkg::KIND_REM_PREV, 10'd682,  10'd0,    1'b0, 10'd0},
    '{clld_pkg::KIND_INS_NEXT, 10'd341,  10'd5,    1'b0, 10'd0},
    '{clld_pkg::KIND_INS_PREV, 10'd0,    10'd0,    1'b0, 10'd0},
    '{clld_pkg::KIND_REM_NEXT, 10'd1023, 10'd682,  1'b0, 10'd0},
    '{clld_pkg::KIND_LOAD,     10'd1023, 10'd5,    1'b0, 10'd0}
  };

  logic clk = 1'b0;
  logic rst;

  clld_in_if  items ();
  clld_out_if results ();

  circular_linked_list_by_id_top uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  always begin
    #PERIOD_HALF clk = 1'b1;
    #PERIOD_HALF clk = 1'b0;
  end

  clld_pkg::id_t  link_next [clld_pkg::NUM_IDS];
  clld_pkg::id_t  link_prev [clld_pkg::NUM_IDS];
  bit             next_known [clld_pkg::NUM_IDS];
  bit             prev_known [clld_pkg::NUM_IDS];
  clld_pkg::id_t  ring_head;
  clld_pkg::id_t  tail_id;
  bit             ring_live;

  bit             in_ring [clld_pkg::NUM_IDS];
  clld_pkg::id_t  members [$];

  clld_pkg::id_t  expected_neighbors [$];
  int             mismatches;
  int             sent_items;
  int             idle_pct;
  int             stall_pct;
  int             quiet_cycles;

  function automatic void set_next(clld_pkg::id_t a, clld_pkg::id_t v);
    link_next[a]  = v;
    next_known[a] = 1'b1;
  endfunction

  function automatic void set_prev(clld_pkg::id_t a, clld_pkg::id_t v);
    link_prev[a]  = v;
    prev_known[a] = 1'b1;
  endfunction

  // applies one beat to the ring copy, returns whether a neighbor is reported
  function automatic bit advance_ring(clld_pkg::kind_t k, clld_pkg::id_t r,
                                      clld_pkg::id_t n, output clld_pkg::id_t nb);
    clld_pkg::id_t far;
    nb = '0;
    case (k)
      clld_pkg::KIND_LOAD: begin
        if (!ring_live) begin
          ring_head = n;
          ring_live = 1'b1;
        end else begin
          set_next(tail_id, n);
          set_prev(n, tail_id);
        end
        set_next(n, ring_head);
        set_prev(ring_head, n);
        tail_id = n;
        return 1'b0;
      end
      clld_pkg::KIND_INS_NEXT: begin
        nb = link_next[r];
        set_next(r, n);
        set_prev(n, r);
        set_next(n, nb);
        set_prev(nb, n);
        return 1'b1;
      end
      clld_pkg::KIND_INS_PREV: begin
        nb = link_prev[r];
        set_next(nb, n);
        set_prev(n, nb);
        set_next(n, r);
        set_prev(r, n);
        return 1'b1;
      end
      clld_pkg::KIND_REM_NEXT: begin
        nb  = link_next[r];
        far = link_next[nb];
        set_next(r, far);
        set_prev(far, r);
        return 1'b1;
      end
      clld_pkg::KIND_REM_PREV: begin
        nb  = link_prev[r];
        far = link_prev[nb];
        set_next(far, r);
        set_prev(r, far);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic clld_pkg::id_t pick_absent();
    clld_pkg::id_t c;
    do c = clld_pkg::id_t'($urandom_range(0, clld_pkg::NUM_IDS - 1)); while (in_ring[c]);
    return c;
  endfunction

  function automatic clld_pkg::id_t any_id();
    return clld_pkg::id_t'($urandom_range(0, clld_pkg::NUM_IDS - 1));
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input clld_pkg::kind_t k, input clld_pkg::id_t r,
                           input clld_pkg::id_t n, input logic typed,
                           input clld_pkg::id_t want);
    clld_pkg::id_t nb;
    logic          has_result;
    while ($urandom_range(0, 99) < idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid  <= 1'b1;
    items.kind   <= k;
    items.ref_id <= r;
    items.new_id <= n;
    do @(posedge clk); while (!items.ready);
    has_result = advance_ring(k, r, n, nb);
    if (has_result) expected_neighbors.push_back(typed ? want : nb);
    if (k <= clld_pkg::KIND_REM_PREV) sent_items++;
    @(negedge clk);
  endtask

  task automatic settle();
    items.valid <= 1'b0;
    while (expected_neighbors.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  always @(negedge clk) results.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (expected_neighbors.size() == 0) begin
        $error("neighbor_id: expected none, got %0d", results.neighbor_id);
        mismatches++;
      end else begin
        if (results.neighbor_id !== expected_neighbors[0]) begin
          $error("neighbor_id: expected %0d, got %0d", expected_neighbors[0],
                 results.neighbor_id);
          mismatches++;
        end
        void'(expected_neighbors.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("circular_linked_list_by_id_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clld_pkg::kind_t k;
    clld_pkg::id_t   r;
    clld_pkg::id_t   n;
    clld_pkg::id_t   victim;
    logic            ok;
    int              goal;
    int              pick;
    int              idx;
    int              idle_mix  [4];
    int              stall_mix [4];

    idle_mix  = '{0, 82, 0, 22};
    stall_mix = '{0, 0, 82, 22};
    rst           = 1'b1;
    items.valid   = 1'b0;
    items.kind    = clld_pkg::KIND_LOAD;
    items.ref_id  = '0;
    items.new_id  = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    sent_items    = 0;
    ring_live     = 1'b0;
    ring_head     = '0;
    tail_id       = '0;
    foreach (next_known[i]) begin
      next_known[i] = 1'b0;
      prev_known[i] = 1'b0;
      link_next[i]  = '0;
      link_prev[i]  = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PLAN[i])
      send_beat(PLAN[i].k, PLAN[i].ref_v, PLAN[i].new_v, PLAN[i].typed, PLAN[i].want);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      goal      = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        // reloading the head id collapses the ring to that single id
        send_beat(clld_pkg::KIND_LOAD, any_id(), ring_head, 1'b0, '0);
        foreach (in_ring[i]) in_ring[i] = 1'b0;
        members.delete();
        in_ring[ring_head] = 1'b1;
        members.push_back(ring_head);
        repeat ($urandom_range(0, 12)) begin
          n = pick_absent();
          send_beat(clld_pkg::KIND_LOAD, any_id(), n, 1'b0, '0);
          in_ring[n] = 1'b1;
          members.push_back(n);
        end

        repeat ($urandom_range(10, 60)) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            k = clld_pkg::kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            send_beat(k, any_id(), any_id(), 1'b0, '0);
          end else begin
            r = members[$urandom_range(0, members.size() - 1)];
            if (members.size() < 2 || (members.size() < 40 && pick < 52)) begin
              n = pick_absent();
              k = pick[0] ? clld_pkg::KIND_INS_NEXT : clld_pkg::KIND_INS_PREV;
              send_beat(k, r, n, 1'b0, '0);
              in_ring[n] = 1'b1;
              members.push_back(n);
            end else begin
              k      = pick[0] ? clld_pkg::KIND_REM_NEXT : clld_pkg::KIND_REM_PREV;
              victim = (k == clld_pkg::KIND_REM_NEXT) ? link_next[r] : link_prev[r];
              send_beat(k, r, any_id(), 1'b0, '0);
              in_ring[victim] = 1'b0;
              idx = -1;
              foreach (members[i]) if (members[i] == victim) idx = i;
              if (idx >= 0) members.delete(idx);
            end
          end
        end

        // broken sequences: any kind; inserts and removes pick an id whose links have been written
        repeat ($urandom_range(0, 3)) begin
          k  = clld_pkg::kind_t'($urandom_range(0, KIND_SPARE_HI));
          r  = '0;
          ok = 1'b0;
          for (int t = 0; t < 32 && !ok; t++) begin
            r = any_id();
            case (k)
              clld_pkg::KIND_INS_NEXT: ok = next_known[r];
              clld_pkg::KIND_INS_PREV: ok = prev_known[r];
              clld_pkg::KIND_REM_NEXT: ok = next_known[r] && next_known[link_next[r]];
              clld_pkg::KIND_REM_PREV: ok = prev_known[r] && prev_known[link_prev[r]];
              default:                 ok = 1'b1;
            endcase
          end
          if (!ok) k = clld_pkg::KIND_LOAD;
          send_beat(k, r, any_id(), 1'b0, '0);
        end
      end
      settle();
    end

    if (mismatches == 0 && expected_neighbors.size() == 0) begin
      $display("circular_linked_list_by_id_top: match");
    end else begin
      $display("circular_linked_list_by_id_top: mismatch");
    end
    $finish;
  end

endmodule
